>>> hw/rtl/wsm_pkg.sv
// Shared types and constants for the windowed sparsity monitor.
// Holds the word structs, the controller command/status structs and the reset values.
// No dependencies.
`timescale 1ns / 1ps

package wsm_pkg;

    // Field widths fixed by the register map and the word formats.
    localparam int ACT_W  = 16;
    localparam int Q_W    = 24;
    localparam int ACC_W  = 37;
    localparam int RT_W   = 35;
    localparam int NEUR_W = 21;
    localparam int WIN_W  = 11;
    localparam int INIT_W = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_NEURONS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE    = 3'd3;

    // Register reset values.
    localparam logic              RST_COUNT_MODE    = 1'b1;
    localparam logic [NEUR_W-1:0] RST_TOTAL_NEURONS = 21'd1;
    localparam int                RST_WINDOW_LEN    = 1000;
    localparam int                RST_INIT_VALUE    = 655;

    // Default sizes handed down from the top level.
    localparam int RING_DEPTH_DEF  = 1024;
    localparam int MAX_NEURONS_DEF = 1048576;

    // Shared divider: rounded numerator and doubled divisor.
    localparam int DIV_NUM_W = 54;
    localparam int DIV_DEN_W = NEUR_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Input and result words.
    typedef struct packed {
        logic signed [ACT_W-1:0] activation;
        logic                    last_in_frame;
    } wsm_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] frame_value;
        logic signed [Q_W-1:0] window_mean;
    } wsm_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic acc_en;
        logic acc_clr;
        logic fv_start;
        logic fv_load;
        logic ring_rd;
        logic ring_upd;
        logic wm_start;
        logic wm_load;
        logic out_load;
    } wsm_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic item_last;
        logic div_done;
        logic out_free;
    } wsm_sts_t;

    // Controller states.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FV_GO    = 8'b0000_0010,
        S_FV_WAIT  = 8'b0000_0100,
        S_RING_RD  = 8'b0000_1000,
        S_RING_UPD = 8'b0001_0000,
        S_WM_GO    = 8'b0010_0000,
        S_WM_WAIT  = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } wsm_state_t;

endpackage

>>> hw/rtl/wsm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the frame value and the window mean divisions.
// Depends on wsm_pkg.
`timescale 1ns / 1ps

module wsm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [wsm_pkg::DIV_NUM_W-1:0]  num,
    input  logic [wsm_pkg::DIV_DEN_W-1:0]  den,
    output logic                           done,
    output logic [wsm_pkg::DIV_NUM_W-1:0]  quo
);
    import wsm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Control of the iteration count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Numerator shifts out on the left while quotient bits shift in on the right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> hw/rtl/wsm_datapath.sv
// Datapath: configuration registers, frame accumulator, history ring, running
// total, divider operand selection and the result register.
// Depends on wsm_pkg and wsm_div.
`timescale 1ns / 1ps

module wsm_datapath #(
    parameter int RING_DEPTH  = wsm_pkg::RING_DEPTH_DEF,
    parameter int MAX_NEURONS = wsm_pkg::MAX_NEURONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wsm_pkg::wsm_in_t                item,
    input  logic                            result_ready,
    output logic                            result_valid,
    output wsm_pkg::wsm_out_t               result,
    input  wsm_pkg::wsm_cmd_t               cmd,
    output wsm_pkg::wsm_sts_t               sts
);
    import wsm_pkg::*;

    localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RST_WIN = (RST_WINDOW_LEN > RING_DEPTH) ? RING_DEPTH : RST_WINDOW_LEN;
    localparam logic [RT_W-1:0]   RST_RING_TOTAL = RT_W'(RST_INIT_VALUE * RST_WIN);
    localparam logic [SLOT_W-1:0] RST_SLOT       = SLOT_W'(RST_WIN - 1);
    localparam logic [Q_W-1:0]    Q_MAX_VAL      = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0]    Q_MIN_VAL      = {1'b1, {(Q_W-1){1'b0}}};

    // Window length clamped to 1..RING_DEPTH.
    function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] wl);
        logic [WIN_W-1:0] r;
        r = wl;
        if (wl == '0)
            r = WIN_W'(1);
        else if (32'(wl) > RING_DEPTH)
            r = WIN_W'(RING_DEPTH);
        return r;
    endfunction

    // Quotient magnitude and sign to a saturated Q8.16 value.
    function automatic logic [Q_W-1:0] sat_q(input logic [DIV_NUM_W-1:0] q, input logic neg);
        logic [Q_W-1:0] r;
        if (!neg)
            r = (q > DIV_NUM_W'(Q_MAX_VAL)) ? Q_MAX_VAL : q[Q_W-1:0];
        else
            r = (q > DIV_NUM_W'(Q_MIN_VAL)) ? Q_MIN_VAL : (~q[Q_W-1:0] + 1'b1);
        return r;
    endfunction

    // Configuration registers.
    logic              count_mode_reg;
    logic [NEUR_W-1:0] total_neurons_reg;
    logic [WIN_W-1:0]  window_len_reg;
    logic [INIT_W-1:0] init_value_reg;

    // Working state.
    logic [ACC_W-1:0]  acc_reg;
    logic [RT_W-1:0]   ring_total_reg;
    logic [SLOT_W-1:0] write_slot_reg;
    logic              filled_reg;
    logic              sign_reg;
    logic [Q_W-1:0]    fv_reg;
    logic [Q_W-1:0]    wm_reg;
    logic [Q_W-1:0]    ring_rd_reg;
    logic              result_valid_reg;
    wsm_out_t          result_reg;

    logic [Q_W-1:0]    ring_mem [RING_DEPTH];

    // Register values after the current write, used for the ring refill.
    logic              cfg_hit;
    logic              count_mode_next;
    logic [NEUR_W-1:0] total_neurons_next;
    logic [WIN_W-1:0]  window_len_next;
    logic [INIT_W-1:0] init_value_next;
    logic [WIN_W-1:0]  win_next_eff;

    always_comb
    begin
        cfg_hit            = 1'b0;
        count_mode_next    = count_mode_reg;
        total_neurons_next = total_neurons_reg;
        window_len_next    = window_len_reg;
        init_value_next    = init_value_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_COUNT_MODE:
                begin
                    cfg_hit         = 1'b1;
                    count_mode_next = cfg_data[0];
                end
                REG_TOTAL_NEURONS:
                begin
                    cfg_hit            = 1'b1;
                    total_neurons_next = cfg_data[NEUR_W-1:0];
                end
                REG_WINDOW_LEN:
                begin
                    cfg_hit         = 1'b1;
                    window_len_next = cfg_data[WIN_W-1:0];
                end
                REG_INIT_VALUE:
                begin
                    cfg_hit         = 1'b1;
                    init_value_next = cfg_data[INIT_W-1:0];
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        win_next_eff = eff_win(window_len_next);
    end

    // Effective divisor and window length.
    logic [NEUR_W-1:0] n_eff;
    logic [WIN_W-1:0]  w_eff;

    always_comb
    begin
        n_eff = total_neurons_reg;
        if (total_neurons_reg == '0)
            n_eff = NEUR_W'(1);
        else if (32'(total_neurons_reg) > MAX_NEURONS)
            n_eff = NEUR_W'(MAX_NEURONS);
        w_eff = eff_win(window_len_reg);
    end

    // Saturating accumulate of one activation.
    logic [ACC_W-1:0] add_val;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sat;

    always_comb
    begin
        if (count_mode_reg)
            add_val = ACC_W'(!item.activation[ACT_W-1] && (item.activation != '0));
        else
            add_val = {{(ACC_W-ACT_W){item.activation[ACT_W-1]}}, item.activation};
        acc_sum = {acc_reg[ACC_W-1], acc_reg} + {add_val[ACC_W-1], add_val};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_sat = acc_sum[ACC_W-1:0];
    end

    // Divider operands: magnitude doubled plus the divisor, over twice the divisor.
    logic [ACC_W-1:0]     acc_mag;
    logic [RT_W-1:0]      rt_mag;
    logic [DIV_NUM_W-2:0] fv_scaled;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    always_comb
    begin
        acc_mag = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        rt_mag  = ring_total_reg[RT_W-1] ? (~ring_total_reg + 1'b1) : ring_total_reg;
        if (count_mode_reg)
            fv_scaled = {acc_mag, 16'b0};
        else
            fv_scaled = {8'b0, acc_mag, 8'b0};
        if (cmd.fv_start)
        begin
            div_num = {fv_scaled, 1'b0} + DIV_NUM_W'(n_eff);
            div_den = {n_eff, 1'b0};
        end
        else
        begin
            div_num = DIV_NUM_W'({rt_mag, 1'b0}) + DIV_NUM_W'(w_eff);
            div_den = DIV_DEN_W'({w_eff, 1'b0});
        end
        div_start = cmd.fv_start | cmd.wm_start;
    end

    wsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Next ring slot, wrapping at the window length.
    logic [SLOT_W-1:0] slot_step;
    logic [Q_W-1:0]    old_entry;
    logic [RT_W-1:0]   rt_update;

    always_comb
    begin
        if ((32'(write_slot_reg) + 1) >= 32'(w_eff))
            slot_step = '0;
        else
            slot_step = write_slot_reg + SLOT_W'(1);
        old_entry = filled_reg ? ring_rd_reg : Q_W'(init_value_reg);
        rt_update = ring_total_reg
                    - {{(RT_W-Q_W){old_entry[Q_W-1]}}, old_entry}
                    + {{(RT_W-Q_W){fv_reg[Q_W-1]}}, fv_reg};
    end

    // Configuration, accumulator and ring bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg    <= RST_COUNT_MODE;
            total_neurons_reg <= RST_TOTAL_NEURONS;
            window_len_reg    <= WIN_W'(RST_WINDOW_LEN);
            init_value_reg    <= INIT_W'(RST_INIT_VALUE);
            acc_reg           <= '0;
            ring_total_reg    <= RST_RING_TOTAL;
            write_slot_reg    <= RST_SLOT;
            filled_reg        <= 1'b0;
        end
        else if (cfg_hit)
        begin
            count_mode_reg    <= count_mode_next;
            total_neurons_reg <= total_neurons_next;
            window_len_reg    <= window_len_next;
            init_value_reg    <= init_value_next;
            acc_reg           <= '0;
            ring_total_reg    <= {{(RT_W-INIT_W){1'b0}}, init_value_next}
                                 * {{(RT_W-WIN_W){1'b0}}, win_next_eff};
            write_slot_reg    <= SLOT_W'(win_next_eff - WIN_W'(1));
            filled_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.acc_clr)
                acc_reg <= '0;
            else if (cmd.acc_en)
                acc_reg <= acc_sat;
            if (cmd.ring_rd)
                write_slot_reg <= slot_step;
            if (cmd.ring_upd)
            begin
                ring_total_reg <= rt_update;
                if (32'(write_slot_reg) == (32'(w_eff) - 1))
                    filled_reg <= 1'b1;
            end
        end
    end

    // History ring storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.ring_upd)
            ring_mem[write_slot_reg] <= fv_reg;
        if (cmd.ring_rd)
            ring_rd_reg <= ring_mem[slot_step];
    end

    // Sign capture and quotient results.
    always_ff @(posedge clk)
    begin
        if (cmd.fv_start)
            sign_reg <= acc_reg[ACC_W-1];
        else if (cmd.wm_start)
            sign_reg <= ring_total_reg[RT_W-1];
        if (cmd.fv_load)
            fv_reg <= sat_q(div_quo, sign_reg);
        if (cmd.wm_load)
            wm_reg <= sat_q(div_quo, sign_reg);
        if (cmd.out_load)
        begin
            result_reg.frame_value <= fv_reg;
            result_reg.window_mean <= wm_reg;
        end
    end

    // Result word holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.out_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    assign result_valid  = result_valid_reg;
    assign result        = result_reg;
    assign sts.item_last = item.last_in_frame;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !result_valid_reg || result_ready;

endmodule

>>> hw/rtl/wsm_ctrl.sv
// Controller state machine: accepts words, sequences the two divisions and the
// ring update at frame end, and hands the result word to the output register.
// Depends on wsm_pkg.
`timescale 1ns / 1ps

module wsm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              cfg_write,
    input  wsm_pkg::wsm_sts_t sts,
    output wsm_pkg::wsm_cmd_t cmd
);
    import wsm_pkg::*;

    wsm_state_t state_reg;
    wsm_state_t state_next;
    logic       item_fire;

    // A word is taken only in idle and never alongside a register write.
    assign item_ready = (state_reg == S_IDLE) && !cfg_write;
    assign item_fire  = item_valid && item_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.acc_en = item_fire;
                if (item_fire && sts.item_last)
                    state_next = S_FV_GO;
            end
            S_FV_GO:
            begin
                cmd.fv_start = 1'b1;
                state_next   = S_FV_WAIT;
            end
            S_FV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.fv_load = 1'b1;
                    state_next  = S_RING_RD;
                end
            end
            S_RING_RD:
            begin
                cmd.ring_rd = 1'b1;
                cmd.acc_clr = 1'b1;
                state_next  = S_RING_UPD;
            end
            S_RING_UPD:
            begin
                cmd.ring_upd = 1'b1;
                state_next   = S_WM_GO;
            end
            S_WM_GO:
            begin
                cmd.wm_start = 1'b1;
                state_next   = S_WM_WAIT;
            end
            S_WM_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.wm_load = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hw/rtl/windowed_sparsity_monitor.sv
// Windowed sparsity monitor top level: a word without the frame end flag is accumulated,
// and the next word may follow at once. A frame end word starts two 54-step runs of the
// shared bit-serial divider, with the ring read and update between them; the next word is
// taken once its result word is loaded, later while the previous result word still waits.
// Reset clears the accumulator, loads the register defaults and treats every ring
// entry as init_value; a register write does the same refill at once, with no sweep.
`timescale 1ns / 1ps

module windowed_sparsity_monitor #(
    parameter int RING_DEPTH  = wsm_pkg::RING_DEPTH_DEF,
    parameter int MAX_NEURONS = wsm_pkg::MAX_NEURONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  wsm_pkg::wsm_in_t                item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output wsm_pkg::wsm_out_t               result
);
    import wsm_pkg::*;

    wsm_cmd_t cmd;
    wsm_sts_t sts;

    // Sequencer.
    wsm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cfg_write  (cfg_write),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Arithmetic, ring and result register.
    wsm_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
